// File: hw/rtl/apt_pkg.sv
// Shared types, constants and register map for the affine point transform.
package apt_pkg;

	// Field widths
	localparam int unsigned CoordW = 32;
	localparam int unsigned CoefW  = 32;
	localparam int unsigned RegW   = 64;
	localparam int unsigned ProdW  = CoordW + CoefW;
	localparam int unsigned FracW  = 16;
	localparam int unsigned SumW   = ProdW + 2;
	localparam int unsigned ShW    = SumW - FracW;
	localparam int unsigned NumCol = 3;
	localparam int unsigned NumReg = 6;
	localparam int unsigned IdxW   = 3;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [SumW-1:0]   sum_t;
	typedef logic [RegW-1:0]          reg_t;

	// Register indexes
	typedef enum logic [IdxW-1:0] {
		REG_COEF_X_A = 3'd0,
		REG_COEF_X_B = 3'd1,
		REG_COEF_Y_A = 3'd2,
		REG_COEF_Y_B = 3'd3,
		REG_COEF_Z_A = 3'd4,
		REG_COEF_Z_B = 3'd5
	} reg_idx_t;

	// Identity reset values
	localparam reg_t CoefXAReset = 64'h0000_0000_0001_0000;
	localparam reg_t CoefXBReset = 64'h0000_0000_0000_0000;
	localparam reg_t CoefYAReset = 64'h0001_0000_0000_0000;
	localparam reg_t CoefYBReset = 64'h0000_0000_0000_0000;
	localparam reg_t CoefZAReset = 64'h0000_0000_0000_0000;
	localparam reg_t CoefZBReset = 64'h0000_0000_0001_0000;

	localparam coord_t CoordMax = 32'sh7FFF_FFFF;
	localparam coord_t CoordMin = 32'sh8000_0000;

	// Result of one column after shift and saturation
	typedef struct packed {
		coord_t value;
		logic   clip;
	} sat_t;

	// Floor shift back to Q16.16 and clamp to the signed 32-bit range
	function automatic sat_t sat_shift(input sum_t s);
		logic signed [ShW-1:0] q;
		sat_t                  r;
		q = ShW'(s >>> FracW);
		if (!q[ShW-1] && (q[ShW-2:CoordW-1] != '0)) begin
			r.value = CoordMax;
			r.clip  = 1'b1;
		end else if (q[ShW-1] && (q[ShW-2:CoordW-1] != '1)) begin
			r.value = CoordMin;
			r.clip  = 1'b1;
		end else begin
			r.value = q[CoordW-1:0];
			r.clip  = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/affine_point_transform_unit.sv
// Affine point transform: four-stage pipeline, one point per clock while the receiver accepts.
//
// Use: a point (x, y, z) in signed Q16.16 arrives as one beat on the
// s_* channel (tdata: pos_x, pos_y, pos_z from the low bits up). The block
// returns x*m0j + y*m1j + z*m2j + m3j for each column j as one beat on
// the m_* channel (tdata: out_x, out_y, out_z), with m_tuser set when any
// coordinate was clamped to the 32-bit range.
// The twelve coefficients are written through cfg_wr_en / cfg_index /
// cfg_data; the user must do so only while no beat is in flight, which the
// block itself does not enforce. Indexes six and seven are ignored. The
// register stages are products, two adder levels, and floor shift with
// saturation. Throughput is one beat per clock while the receiver accepts;
// the nine 32x32 multipliers then take a new point every cycle.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, the last stage holds its beat and earlier
// stages keep filling until each holds a beat; s_tready then falls.
module affine_point_transform_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration
	input  logic                    cfg_wr_en,
	input  logic [apt_pkg::IdxW-1:0] cfg_index,
	input  logic [apt_pkg::RegW-1:0] cfg_data,
	// Input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [95:0]             s_tdata,   // pos_x, pos_y, pos_z
	// Output stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [95:0]             m_tdata,   // out_x, out_y, out_z
	output logic                    m_tuser    // clipped
);

	localparam int unsigned CW = apt_pkg::CoordW;

	// Coefficient registers
	apt_pkg::reg_t coef_q [apt_pkg::NumReg];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[apt_pkg::REG_COEF_X_A] <= apt_pkg::CoefXAReset;
			coef_q[apt_pkg::REG_COEF_X_B] <= apt_pkg::CoefXBReset;
			coef_q[apt_pkg::REG_COEF_Y_A] <= apt_pkg::CoefYAReset;
			coef_q[apt_pkg::REG_COEF_Y_B] <= apt_pkg::CoefYBReset;
			coef_q[apt_pkg::REG_COEF_Z_A] <= apt_pkg::CoefZAReset;
			coef_q[apt_pkg::REG_COEF_Z_B] <= apt_pkg::CoefZBReset;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				apt_pkg::REG_COEF_X_A: coef_q[apt_pkg::REG_COEF_X_A] <= cfg_data;
				apt_pkg::REG_COEF_X_B: coef_q[apt_pkg::REG_COEF_X_B] <= cfg_data;
				apt_pkg::REG_COEF_Y_A: coef_q[apt_pkg::REG_COEF_Y_A] <= cfg_data;
				apt_pkg::REG_COEF_Y_B: coef_q[apt_pkg::REG_COEF_Y_B] <= cfg_data;
				apt_pkg::REG_COEF_Z_A: coef_q[apt_pkg::REG_COEF_Z_A] <= cfg_data;
				apt_pkg::REG_COEF_Z_B: coef_q[apt_pkg::REG_COEF_Z_B] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage valids and load enables; bubbles collapse
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en1, en2, en3, en4;

	assign en4      = !vld_s4 || m_tready;
	assign en3      = !vld_s3 || en4;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	// Input coordinates
	apt_pkg::coord_t pos [3];
	assign pos[0] = s_tdata[CW-1:0];
	assign pos[1] = s_tdata[2*CW-1:CW];
	assign pos[2] = s_tdata[3*CW-1:2*CW];

	logic [apt_pkg::NumCol-1:0] clip_col;
	apt_pkg::coord_t            res_s4 [apt_pkg::NumCol];
	logic [apt_pkg::NumCol-1:0] clip_s4;

	for (genvar j = 0; j < apt_pkg::NumCol; j++) begin : g_col
		apt_pkg::reg_t   reg_a, reg_b;
		apt_pkg::coord_t m0, m1, m2, tr;
		apt_pkg::prod_t  p0_s1, p1_s1, p2_s1;
		apt_pkg::coord_t tr_s1;
		apt_pkg::sum_t   sa_s2, sb_s2, sum_s3;
		apt_pkg::sat_t   sat;

		assign reg_a = coef_q[2*j];
		assign reg_b = coef_q[2*j+1];
		assign m0    = reg_a[CW-1:0];
		assign m1    = reg_a[2*CW-1:CW];
		assign m2    = reg_b[CW-1:0];
		assign tr    = reg_b[2*CW-1:CW];

		// Stage 1: exact Q32.32 products
		always_ff @(posedge clk) begin
			if (en1 && s_tvalid) begin
				p0_s1 <= apt_pkg::ProdW'(pos[0] * m0);
				p1_s1 <= apt_pkg::ProdW'(pos[1] * m1);
				p2_s1 <= apt_pkg::ProdW'(pos[2] * m2);
				tr_s1 <= tr;
			end
		end

		// Stage 2: pairwise sums, translation aligned to Q32.32
		always_ff @(posedge clk) begin
			if (en2 && vld_s1) begin
				sa_s2 <= apt_pkg::SumW'(p0_s1) + apt_pkg::SumW'(p1_s1);
				sb_s2 <= apt_pkg::SumW'(p2_s1)
					+ (apt_pkg::SumW'(tr_s1) <<< apt_pkg::FracW);
			end
		end

		// Stage 3: full sum
		always_ff @(posedge clk) begin
			if (en3 && vld_s2) begin
				sum_s3 <= sa_s2 + sb_s2;
			end
		end

		// Stage 4: floor shift and saturation
		assign sat         = apt_pkg::sat_shift(sum_s3);
		assign clip_col[j] = sat.clip;

		always_ff @(posedge clk) begin
			if (en4 && vld_s3) begin
				res_s4[j]  <= sat.value;
				clip_s4[j] <= clip_col[j];
			end
		end
	end

	// Output beat
	assign m_tvalid = vld_s4;
	assign m_tdata  = {res_s4[2], res_s4[1], res_s4[0]};
	assign m_tuser  = |clip_s4;

endmodule
